// ----- sv/fkin_pkg.sv -----
// ----------------------------------------------------------------------------
// fkin_pkg
// Shared constants, payload types and helper functions of the six-axis
// forward kinematics pipeline.
// ----------------------------------------------------------------------------
package fkin_pkg;

	localparam int ANGLE_W = 16;
	localparam int POS_W   = 18;
	localparam int NJ      = 6;
	localparam int NROT    = 30;
	localparam int NSQ     = 32;
	localparam int ZW      = 36;
	localparam int CW      = 36;
	localparam int MW      = 34;
	localparam int PW      = 52;
	localparam int VW      = 36;
	localparam int AW      = 34;
	localparam int QSH     = 33 - ANGLE_W;
	localparam int ASH     = 33 - ANGLE_W;
	localparam int PSH     = 48 - POS_W;

	localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'sd3373259426);
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
	localparam logic signed [CW-1:0] GAIN_Q30    = CW'(64'sd652032874);
	localparam logic signed [MW-1:0] ONE_Q30     = MW'(64'sd1073741824);
	localparam logic signed [2*MW:0] RND_Q30     = (2*MW+1)'(64'sd536870912);

	localparam logic [15:0] RST_D1   = 16'd17170;
	localparam logic [15:0] RST_A3   = 16'd14746;
	localparam logic [15:0] RST_D4   = 16'd15001;
	localparam logic [15:0] RST_D6   = 16'd3604;
	localparam logic [15:0] RST_ZOFF = 16'd1442;

	// link numbers, joint 1 is link 0
	localparam logic [2:0] LK1 = 3'd0;
	localparam logic [2:0] LK2 = 3'd1;
	localparam logic [2:0] LK3 = 3'd2;
	localparam logic [2:0] LK4 = 3'd3;
	localparam logic [2:0] LK5 = 3'd4;
	localparam logic [2:0] LK6 = 3'd5;

	typedef enum logic [2:0] {
		REG_D1   = 3'd0,
		REG_A3   = 3'd1,
		REG_D4   = 3'd2,
		REG_D6   = 3'd3,
		REG_ZOFF = 3'd4
	} reg_idx_t;

	typedef logic signed [MW-1:0] mval_t;
	typedef logic signed [PW-1:0] pval_t;
	typedef logic signed [VW-1:0] vval_t;
	typedef logic signed [AW-1:0] aval_t;

	typedef struct packed {
		logic [15:0] d1;
		logic [15:0] a3;
		logic [15:0] d4;
		logic [15:0] d6;
		logic [15:0] zoff;
	} cfg_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 neg;
	} rot_lane_t;

	typedef rot_lane_t [NJ-1:0] rot_vec_t;

	typedef struct packed {
		mval_t c;
		mval_t s;
	} cs_t;

	// col[j][r]: column j, row r
	typedef struct packed {
		cs_t   [NJ-1:0]  cs;
		mval_t [2:0][2:0] col;
		pval_t [2:0]     p;
	} link_t;

	typedef struct packed {
		logic [63:0]             n;
		logic [63:0]             r;
		mval_t                   py;
		mval_t                   yx;
		mval_t                   yy;
		mval_t                   rx;
		mval_t                   ry;
		logic [2:0][POS_W-1:0]   pos;
	} sq_t;

	typedef struct packed {
		vval_t x;
		vval_t y;
		aval_t z;
		logic  zero;
	} vec_lane_t;

	// lanes: pitch, yaw, roll
	typedef struct packed {
		vec_lane_t [2:0]       ln;
		logic                  gimbal;
		logic [2:0][POS_W-1:0] pos;
	} vec_t;

	function automatic logic [30:0] atan_q30(input logic [4:0] i);
		logic [30:0] v;
		case (i)
			5'd0: v = 31'd843314857;
			5'd1: v = 31'd497837829;
			5'd2: v = 31'd263043837;
			5'd3: v = 31'd133525159;
			5'd4: v = 31'd67021687;
			5'd5: v = 31'd33543516;
			5'd6: v = 31'd16775851;
			5'd7: v = 31'd8388437;
			5'd8: v = 31'd4194283;
			5'd9: v = 31'd2097149;
			default: v = 31'(32'h4000_0000 >> i);
		endcase
		return v;
	endfunction

	function automatic logic [POS_W-1:0] pos_pack(input pval_t v);
		pval_t t;
		pval_t hi;
		pval_t lo;
		hi = PW'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
		lo = -hi - PW'(1);
		t = (v + (PW'(64'sd1) <<< (PSH - 1))) >>> PSH;
		if (t > hi)
			t = hi;
		else if (t < lo)
			t = lo;
		return t[POS_W-1:0];
	endfunction

	function automatic logic [ANGLE_W-1:0] ang_pack(input aval_t v);
		aval_t t;
		aval_t hi;
		aval_t lo;
		hi = AW'((64'sd1 <<< (ANGLE_W - 1)) - 64'sd1);
		lo = -hi - AW'(1);
		t = (v + (AW'(64'sd1) <<< (ASH - 1))) >>> ASH;
		if (t > hi)
			t = hi;
		else if (t < lo)
			t = lo;
		return t[ANGLE_W-1:0];
	endfunction

	// quadrant fold ahead of the vectoring rotation
	function automatic vec_lane_t vec_start(input vval_t x, input vval_t y);
		vec_lane_t l;
		l.zero = (x == '0) && (y == '0);
		l.x = x;
		l.y = y;
		l.z = '0;
		if (x < 0) begin
			if (y >= 0) begin
				l.x = y;
				l.y = -x;
				l.z = AW'(HALF_PI_Q30);
			end else begin
				l.x = -y;
				l.y = x;
				l.z = -AW'(HALF_PI_Q30);
			end
		end
		return l;
	endfunction

endpackage

// ----- sv/dh_forward_kinematics_6dof.sv -----
// ----------------------------------------------------------------------------
// dh_forward_kinematics_6dof
// Six-axis modified-DH forward kinematics: joint angles in, pose out.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per clock, unless the output is stalled. The depth
// is set by the cell chains: 30 sine/cosine CORDIC cells, 6 link cells, 32
// square-root cells and 30 atan2 CORDIC cells, plus five glue stages. The
// whole chain advances together and holds while a result waits on m_tready.
// Link lengths are read live, so write them only with the pipeline empty.
module dh_forward_kinematics_6dof import fkin_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// joint1_angle .. joint6_angle
	input  logic [6*ANGLE_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle, zero pad
	output logic [103:0]         m_tdata,
	// gimbal_lock
	output logic                 m_tuser,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_idx,
	input  logic [15:0]          cfg_data
);

	localparam int NSTG = 1 + NROT + 1 + NJ + 1 + NSQ + 1 + NROT + 1;

	cfg_t cfg_q;
	logic [NSTG-1:0] vld_q;
	logic en;

	rot_vec_t red_c;
	rot_vec_t rot_w [0:NROT];
	link_t    lnk_c;
	link_t    lnk_w [0:NJ];
	sq_t      sq_c;
	sq_t      sq_w [0:NSQ];
	vec_t     vec_c;
	vec_t     vec_w [0:NROT];

	rot_vec_t red_s1;
	link_t    lnk_s2;
	sq_t      sq_s3;
	vec_t     vec_s4;
	logic [101:0] out_s5;
	logic         gim_s5;

	logic signed [ZW-1:0] zq;
	logic signed [2*MW:0] m2;
	pval_t pz;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[NSTG-1];
	assign m_tdata = {2'b00, out_s5};
	assign m_tuser = gim_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.d1 <= RST_D1;
			cfg_q.a3 <= RST_A3;
			cfg_q.d4 <= RST_D4;
			cfg_q.d6 <= RST_D6;
			cfg_q.zoff <= RST_ZOFF;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_D1:   cfg_q.d1 <= cfg_data;
				REG_A3:   cfg_q.a3 <= cfg_data;
				REG_D4:   cfg_q.d4 <= cfg_data;
				REG_D6:   cfg_q.d6 <= cfg_data;
				REG_ZOFF: cfg_q.zoff <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NSTG-2:0], s_tvalid};
	end

	// angle fold into [-pi/2, pi/2]
	always_comb begin
		red_c = '0;
		zq = '0;
		for (int j = 0; j < NJ; j++) begin
			zq = ZW'($signed(s_tdata[j*ANGLE_W +: ANGLE_W])) <<< QSH;
			red_c[j].x = GAIN_Q30;
			red_c[j].y = '0;
			red_c[j].neg = 1'b0;
			if (zq > HALF_PI_Q30) begin
				zq = zq - PI_Q30;
				red_c[j].neg = 1'b1;
			end else if (zq < -HALF_PI_Q30) begin
				zq = zq + PI_Q30;
				red_c[j].neg = 1'b1;
			end
			red_c[j].z = zq;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			red_s1 <= red_c;
	end

	assign rot_w[0] = red_s1;

	for (genvar g = 0; g < NROT; g++) begin : g_rot
		fkin_rot_cell u_cell (
			.clk  (clk),
			.en   (en),
			.step (5'(g)),
			.d    (rot_w[g]),
			.q    (rot_w[g+1])
		);
	end

	always_comb begin
		lnk_c = '0;
		for (int j = 0; j < NJ; j++) begin
			lnk_c.cs[j].c = rot_w[NROT][j].neg ? MW'(-rot_w[NROT][j].x) : MW'(rot_w[NROT][j].x);
			lnk_c.cs[j].s = rot_w[NROT][j].neg ? MW'(-rot_w[NROT][j].y) : MW'(rot_w[NROT][j].y);
		end
		for (int k = 0; k < 3; k++)
			lnk_c.col[k][k] = ONE_Q30;
	end

	always_ff @(posedge clk) begin
		if (en)
			lnk_s2 <= lnk_c;
	end

	assign lnk_w[0] = lnk_s2;

	for (genvar g = 0; g < NJ; g++) begin : g_link
		fkin_link_cell u_cell (
			.clk  (clk),
			.en   (en),
			.link (3'(g)),
			.cfg  (cfg_q),
			.d    (lnk_w[g]),
			.q    (lnk_w[g+1])
		);
	end

	// r00 = c0[0], r10 = c0[1], r20 = c0[2], r21 = -c2[2], r22 = c1[2]
	always_comb begin
		m2 = lnk_w[NJ].col[0][0] * lnk_w[NJ].col[0][0]
			+ lnk_w[NJ].col[0][1] * lnk_w[NJ].col[0][1];
		pz = lnk_w[NJ].p[2] + (PW'(cfg_q.zoff) <<< 30);
		sq_c.n = 64'(m2);
		sq_c.r = '0;
		sq_c.py = -lnk_w[NJ].col[0][2];
		sq_c.yx = lnk_w[NJ].col[0][0];
		sq_c.yy = lnk_w[NJ].col[0][1];
		sq_c.rx = lnk_w[NJ].col[1][2];
		sq_c.ry = -lnk_w[NJ].col[2][2];
		sq_c.pos[0] = pos_pack(lnk_w[NJ].p[0]);
		sq_c.pos[1] = pos_pack(lnk_w[NJ].p[1]);
		sq_c.pos[2] = pos_pack(pz);
	end

	always_ff @(posedge clk) begin
		if (en)
			sq_s3 <= sq_c;
	end

	assign sq_w[0] = sq_s3;

	for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
		fkin_sqrt_cell u_cell (
			.clk  (clk),
			.en   (en),
			.step (5'(g)),
			.d    (sq_w[g]),
			.q    (sq_w[g+1])
		);
	end

	always_comb begin
		vec_c.ln[0] = vec_start(VW'(sq_w[NSQ].r), VW'(sq_w[NSQ].py));
		vec_c.ln[1] = vec_start(VW'(sq_w[NSQ].yx), VW'(sq_w[NSQ].yy));
		vec_c.ln[2] = vec_start(VW'(sq_w[NSQ].rx), VW'(sq_w[NSQ].ry));
		vec_c.gimbal = (sq_w[NSQ].r == '0);
		vec_c.pos = sq_w[NSQ].pos;
	end

	always_ff @(posedge clk) begin
		if (en)
			vec_s4 <= vec_c;
	end

	assign vec_w[0] = vec_s4;

	for (genvar g = 0; g < NROT; g++) begin : g_vec
		fkin_vec_cell u_cell (
			.clk  (clk),
			.en   (en),
			.step (5'(g)),
			.d    (vec_w[g]),
			.q    (vec_w[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s5[POS_W-1:0] <= vec_w[NROT].pos[0];
			out_s5[2*POS_W-1:POS_W] <= vec_w[NROT].pos[1];
			out_s5[3*POS_W-1:2*POS_W] <= vec_w[NROT].pos[2];
			out_s5[3*POS_W +: ANGLE_W] <=
				(vec_w[NROT].gimbal || vec_w[NROT].ln[2].zero) ? '0
				: ang_pack(vec_w[NROT].ln[2].z);
			out_s5[3*POS_W+ANGLE_W +: ANGLE_W] <=
				vec_w[NROT].ln[0].zero ? '0 : ang_pack(vec_w[NROT].ln[0].z);
			out_s5[3*POS_W+2*ANGLE_W +: ANGLE_W] <=
				(vec_w[NROT].gimbal || vec_w[NROT].ln[1].zero) ? '0
				: ang_pack(vec_w[NROT].ln[1].z);
			gim_s5 <= vec_w[NROT].gimbal;
		end
	end

endmodule

// ----- sv/fkin_rot_cell.sv -----
// ----------------------------------------------------------------------------
// fkin_rot_cell
// One rotation-mode CORDIC step for all six joint sine/cosine lanes.
// ----------------------------------------------------------------------------
module fkin_rot_cell import fkin_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  logic [4:0] step,
	input  rot_vec_t d,
	output rot_vec_t q
);

	rot_vec_t nx;

	always_comb begin
		nx = d;
		for (int j = 0; j < NJ; j++) begin
			if (!d[j].z[ZW-1]) begin
				nx[j].x = d[j].x - (d[j].y >>> step);
				nx[j].y = d[j].y + (d[j].x >>> step);
				nx[j].z = d[j].z - ZW'(atan_q30(step));
			end else begin
				nx[j].x = d[j].x + (d[j].y >>> step);
				nx[j].y = d[j].y - (d[j].x >>> step);
				nx[j].z = d[j].z + ZW'(atan_q30(step));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nx;
	end

endmodule

// ----- sv/fkin_link_cell.sv -----
// ----------------------------------------------------------------------------
// fkin_link_cell
// Applies one modified-DH link transform to the running frame.
// ----------------------------------------------------------------------------
module fkin_link_cell import fkin_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  logic [2:0] link,
	input  cfg_t       cfg,
	input  link_t      d,
	output link_t      q
);

	link_t nx;
	mval_t ct;
	mval_t st;
	mval_t u;
	mval_t n2;
	mval_t c0;
	logic signed [16:0] la;
	logic signed [16:0] ld;
	logic signed [2*MW:0] acc0;
	logic signed [2*MW:0] acc1;

	always_comb begin
		nx = d;
		ct = d.cs[link].c;
		st = d.cs[link].s;
		la = '0;
		ld = '0;
		u = '0;
		n2 = '0;
		c0 = '0;
		acc0 = '0;
		acc1 = '0;
		case (link)
			LK2: begin
				ct = -d.cs[link].s;
				st = d.cs[link].c;
			end
			LK5: begin
				ct = d.cs[link].s;
				st = -d.cs[link].c;
			end
			default: ;
		endcase
		case (link)
			LK1: ld = $signed({1'b0, cfg.d1});
			LK3: la = $signed({1'b0, cfg.a3});
			LK4: ld = $signed({1'b0, cfg.d4});
			LK6: ld = $signed({1'b0, cfg.d6});
			default: ;
		endcase
		for (int r = 0; r < 3; r++) begin
			c0 = d.col[0][r];
			case (link)
				LK1, LK3: begin
					u = d.col[1][r];
					n2 = d.col[2][r];
				end
				LK5: begin
					u = -d.col[2][r];
					n2 = d.col[1][r];
				end
				default: begin
					u = d.col[2][r];
					n2 = -d.col[1][r];
				end
			endcase
			nx.p[r] = d.p[r] + la * c0 + ld * n2;
			acc0 = ct * c0 + st * u + RND_Q30;
			acc1 = ct * u - st * c0 + RND_Q30;
			nx.col[0][r] = MW'(acc0 >>> 30);
			nx.col[1][r] = MW'(acc1 >>> 30);
			nx.col[2][r] = n2;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nx;
	end

endmodule

// ----- sv/fkin_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// fkin_sqrt_cell
// One restoring square-root step, two radicand bits per cell.
// ----------------------------------------------------------------------------
module fkin_sqrt_cell import fkin_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  logic [4:0] step,
	input  sq_t        d,
	output sq_t        q
);

	sq_t nx;
	logic [63:0] bt;
	logic [63:0] t;

	always_comb begin
		nx = d;
		bt = 64'h4000_0000_0000_0000 >> {step, 1'b0};
		t = d.r + bt;
		if (d.n >= t) begin
			nx.n = d.n - t;
			nx.r = (d.r >> 1) + bt;
		end else begin
			nx.r = d.r >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nx;
	end

endmodule

// ----- sv/fkin_vec_cell.sv -----
// ----------------------------------------------------------------------------
// fkin_vec_cell
// One vectoring-mode CORDIC step for the pitch, yaw and roll lanes.
// ----------------------------------------------------------------------------
module fkin_vec_cell import fkin_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  logic [4:0] step,
	input  vec_t       d,
	output vec_t       q
);

	vec_t nx;

	always_comb begin
		nx = d;
		for (int k = 0; k < 3; k++) begin
			if (!d.ln[k].y[VW-1]) begin
				nx.ln[k].x = d.ln[k].x + (d.ln[k].y >>> step);
				nx.ln[k].y = d.ln[k].y - (d.ln[k].x >>> step);
				nx.ln[k].z = d.ln[k].z + AW'(atan_q30(step));
			end else begin
				nx.ln[k].x = d.ln[k].x - (d.ln[k].y >>> step);
				nx.ln[k].y = d.ln[k].y + (d.ln[k].x >>> step);
				nx.ln[k].z = d.ln[k].z - AW'(atan_q30(step));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			q <= nx;
	end

endmodule

// ----- tb/sv/fkin_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fkin_checker
// Watches the joint-angle request channel, the pose result channel and the
// register port of the forward kinematics block. It computes the pose of
// every accepted request, queues it, and compares each result with the
// oldest queued pose, field by field.
// ----------------------------------------------------------------------------
module fkin_checker import fkin_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [6*ANGLE_W-1:0] s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [103:0]         m_tdata,
	input  logic                 m_tuser,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_idx,
	input  logic [15:0]          cfg_data,
	output int                   fail_cnt,
	output int                   pose_pending
);

	typedef struct {
		logic [POS_W-1:0]   px;
		logic [POS_W-1:0]   py;
		logic [POS_W-1:0]   pz;
		logic [ANGLE_W-1:0] roll;
		logic [ANGLE_W-1:0] pitch;
		logic [ANGLE_W-1:0] yaw;
		logic               gimbal;
	} pose_t;

	localparam longint ATAN_LUT [30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2};
	localparam longint PI_L      = 64'sd3373259426;
	localparam longint HALF_PI_L = 64'sd1686629713;
	localparam int     COS_TWIST [6] = '{1, 0, 1, 0, 0, 0};
	localparam int     SIN_TWIST [6] = '{0, 1, 0, 1, -1, 1};

	logic [15:0] d1, a3, d4, d6, zoff;
	pose_t       pose_q [$];

	function automatic longint rnd_sh(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(longint v, int w);
		longint hi;
		hi = (64'sd1 <<< (w - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void sin_cos(input longint ang, output longint c, output longint s);
		longint x, y, z, dx, dy;
		bit     flip;
		x = 652032874;
		y = 0;
		z = ang;
		flip = 0;
		if (z > HALF_PI_L) begin
			z -= PI_L;
			flip = 1;
		end else if (z < -HALF_PI_L) begin
			z += PI_L;
			flip = 1;
		end
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_LUT[i];
			end else begin
				x += dx; y -= dy; z += ATAN_LUT[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint arctan2(longint y, longint x);
		longint z, t, nx, ny;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HALF_PI_L;
			end else begin
				x = -y; y = t; z = -HALF_PI_L;
			end
		end
		for (int i = 0; i < 30; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_LUT[i];
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_LUT[i];
			end
			x = nx;
			y = ny;
		end
		return z;
	endfunction

	function automatic pose_t solve_pose(logic [6*ANGLE_W-1:0] joints);
		longint               col [3][3];
		longint               p [3];
		longint               c, s, ct, st, a, d, u, n2, n0, n1, m, roll, pitch, yaw;
		longint unsigned      mag2;
		logic signed [15:0]   q;
		pose_t                r;
		for (int j = 0; j < 3; j++) begin
			p[j] = 0;
			for (int k = 0; k < 3; k++)
				col[j][k] = (j == k) ? 64'sd1073741824 : 0;
		end
		for (int i = 0; i < 6; i++) begin
			q = joints[i*ANGLE_W +: ANGLE_W];
			sin_cos(longint'(q) * (64'sd1 <<< QSH), c, s);
			ct = c;
			st = s;
			if (i == 1) begin ct = -s; st = c; end
			if (i == 4) begin ct = s; st = -c; end
			a = (i == 2) ? longint'(a3) : 0;
			d = (i == 0) ? longint'(d1) : (i == 3) ? longint'(d4) :
				(i == 5) ? longint'(d6) : 0;
			for (int k = 0; k < 3; k++) begin
				u  = COS_TWIST[i] * col[1][k] + SIN_TWIST[i] * col[2][k];
				n2 = -SIN_TWIST[i] * col[1][k] + COS_TWIST[i] * col[2][k];
				p[k] += a * col[0][k] + d * n2;
				n0 = rnd_sh(ct * col[0][k] + st * u, 30);
				n1 = rnd_sh(ct * u - st * col[0][k], 30);
				col[0][k] = n0;
				col[1][k] = n1;
				col[2][k] = n2;
			end
		end
		mag2 = longint'(col[0][0] * col[0][0]) + longint'(col[0][1] * col[0][1]);
		m = longint'(root64(mag2));
		pitch = arctan2(-col[0][2], m);
		if (m == 0) begin
			roll = 0;
			yaw = 0;
		end else begin
			yaw = arctan2(col[0][1], col[0][0]);
			roll = arctan2(-col[2][2], col[1][2]);
		end
		p[2] += longint'(zoff) * (64'sd1 <<< 30);
		r.px     = POS_W'(clamp(rnd_sh(p[0], PSH), POS_W));
		r.py     = POS_W'(clamp(rnd_sh(p[1], PSH), POS_W));
		r.pz     = POS_W'(clamp(rnd_sh(p[2], PSH), POS_W));
		r.roll   = ANGLE_W'(clamp(rnd_sh(roll, ASH), ANGLE_W));
		r.pitch  = ANGLE_W'(clamp(rnd_sh(pitch, ASH), ANGLE_W));
		r.yaw    = ANGLE_W'(clamp(rnd_sh(yaw, ASH), ANGLE_W));
		r.gimbal = (m == 0);
		return r;
	endfunction

	function automatic int field_ok(string name, longint want, longint got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			return 0;
		end
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pose_t want;
		int    ok;
		if (!arst_n) begin
			d1 <= RST_D1;
			a3 <= RST_A3;
			d4 <= RST_D4;
			d6 <= RST_D6;
			zoff <= RST_ZOFF;
			fail_cnt <= 0;
			pose_pending <= 0;
			pose_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				pose_q = {pose_q, solve_pose(s_tdata)};
			if (m_tvalid && m_tready) begin
				if (pose_q.size() == 0) begin
					$error("pose result with no request outstanding");
					fail_cnt <= fail_cnt + 1;
				end else begin
					want = pose_q.pop_front();
					ok = 1;
					ok &= field_ok("pos_x", $signed(want.px), $signed(m_tdata[17:0]));
					ok &= field_ok("pos_y", $signed(want.py), $signed(m_tdata[35:18]));
					ok &= field_ok("pos_z", $signed(want.pz), $signed(m_tdata[53:36]));
					ok &= field_ok("roll_angle", $signed(want.roll),
						$signed(m_tdata[69:54]));
					ok &= field_ok("pitch_angle", $signed(want.pitch),
						$signed(m_tdata[85:70]));
					ok &= field_ok("yaw_angle", $signed(want.yaw),
						$signed(m_tdata[101:86]));
					ok &= field_ok("gimbal_lock", want.gimbal, m_tuser);
					if (!ok)
						fail_cnt <= fail_cnt + 1;
				end
			end
			pose_pending <= pose_q.size();
			if (cfg_we) begin
				case (cfg_idx)
					REG_D1:   d1 <= cfg_data;
					REG_A3:   a3 <= cfg_data;
					REG_D4:   d4 <= cfg_data;
					REG_D6:   d6 <= cfg_data;
					REG_ZOFF: zoff <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- tb/sv/tb_dh_forward_kinematics_6dof.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dh_forward_kinematics_6dof
// Drives joint-angle requests and link-length settings into the forward
// kinematics block under random source gaps and sink stalls; the checker
// beside the block predicts and compares every pose.
// ----------------------------------------------------------------------------
module tb_dh_forward_kinematics_6dof import fkin_pkg::*; ();

	localparam logic [2:0] IDX_UNUSED = 3'd7;
	localparam int         PIPE_LAT   = 103;
	localparam int         CYC_LIMIT  = 400000;
	localparam int         NUM_PHASES = 5;
	localparam int         PHASE_REQS = 200;
	localparam logic [15:0] HALF_PI_A = 16'd12868;
	localparam logic [15:0] PI_A      = 16'd25736;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [6*ANGLE_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [103:0]         m_tdata;
	logic                 m_tuser;
	logic                 cfg_we;
	logic [2:0]           cfg_idx;
	logic [15:0]          cfg_data;
	int                   fail_cnt;
	int                   pose_pending;
	int                   cyc = 0;
	bit                   calm;

	dh_forward_kinematics_6dof uut (.*);

	fkin_checker chk (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYC_LIMIT) begin
			$display("dh_forward_kinematics_6dof: mismatch");
			$finish;
		end
	end

	// sink: stall a random number of cycles before each result
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = calm ? 0 : $urandom_range(0, 5);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic logic [15:0] pick_angle();
		logic [15:0] j;
		j = 16'($urandom_range(0, 15)) - 16'd8;
		case ($urandom_range(0, 5))
			0: return HALF_PI_A + j;
			1: return -HALF_PI_A + j;
			2: return PI_A + j;
			3: return j;
			4: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [6*ANGLE_W-1:0] pick_joints();
		logic [6*ANGLE_W-1:0] v;
		if ($urandom_range(0, 1))
			return {$urandom, $urandom, $urandom};
		for (int i = 0; i < 6; i++)
			v[i*ANGLE_W +: ANGLE_W] = pick_angle();
		return v;
	endfunction

	task automatic send_request(input logic [6*ANGLE_W-1:0] joints);
		int n;
		n = calm ? 0 : $urandom_range(0, 5);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_tdata <= joints;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pose_pending != 0 || !s_tready)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_links(input logic [15:0] v [5]);
		cfg_we <= 1'b1;
		for (int i = 0; i < 5; i++) begin
			cfg_idx <= 3'(i);
			cfg_data <= v[i];
			@(negedge clk);
		end
		cfg_idx <= IDX_UNUSED;
		cfg_data <= 16'hffff;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] lv [5];
		logic [6*ANGLE_W-1:0] dj;
		calm = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_D1;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request('0);
		send_request({6{16'h7fff}});
		send_request({6{16'h8000}});
		send_request({3{16'h7fff, 16'h8000}});
		send_request({6{16'h5555}});
		send_request({6{16'haaaa}});
		for (int i = 0; i < 6; i++) begin
			dj = '0;
			dj[i*ANGLE_W +: ANGLE_W] = HALF_PI_A;
			send_request(dj);
			dj[i*ANGLE_W +: ANGLE_W] = -HALF_PI_A;
			send_request(dj);
		end
		// wrist folded back onto the shoulder axis
		send_request({16'd0, HALF_PI_A, 16'd0, 16'd0, -HALF_PI_A, 16'd0});
		send_request({16'd0, -HALF_PI_A, 16'd0, 16'd0, HALF_PI_A, 16'd0});
		send_request({16'd0, 16'd0, 16'd0, 16'd0, 16'd0, HALF_PI_A});
		send_request({PI_A, -PI_A, PI_A, -PI_A, PI_A, -PI_A});
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			for (int i = 0; i < 5; i++) begin
				case (ph)
					0: lv[i] = 16'h0000;
					1: lv[i] = 16'hffff;
					default: lv[i] = 16'($urandom);
				endcase
			end
			write_links(lv);
			calm = (ph == 2);
			for (int k = 0; k < PHASE_REQS; k++) begin
				if (ph > 2 && k % 50 == 0)
					calm = ~calm;
				send_request(pick_joints());
			end
			drain();
		end

		calm = 1'b0;
		repeat (PIPE_LAT + 10) @(negedge clk);
		if (fail_cnt == 0 && pose_pending == 0)
			$display("dh_forward_kinematics_6dof: match");
		else
			$display("dh_forward_kinematics_6dof: mismatch");
		$finish;
	end

endmodule
